@@ src/lpbd_pkg.sv @@
`timescale 1ns / 1ps

package lpbd_pkg;

    // fixed field widths
    localparam int MODE_W     = 3;
    localparam int PAGE_W     = 20;
    localparam int FRAME_W    = 4;
    localparam int FIU_W      = 5;
    localparam int TOTAL_W    = 21;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 21;

    // request modes
    localparam logic [MODE_W-1:0] MODE_FETCH     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_UNPIN     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FLUSH     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DELETE    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FLUSH_ALL = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAMES_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_PAGES   = 2'd1;

    // register reset values
    localparam logic [FIU_W-1:0]   FIU_RESET   = 5'd16;
    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 21'd1048576;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic emit;
        logic advance;
    } lpbd_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic out_free;
        logic flush_all;
        logic pend_any;
        logic scan_hit;
        logic scan_last;
    } lpbd_sts_t;

    // one result item
    typedef struct packed {
        logic               found;
        logic [FRAME_W-1:0] frame;
        logic               writeback;
        logic [PAGE_W-1:0]  wb_page;
        logic               read_fill;
        logic               erase_block;
        logic               range_error;
        logic               last;
    } lpbd_rsp_t;

endpackage

@@ src/lpbd_if.sv @@
`timescale 1ns / 1ps

// request channel
interface lpbd_req_if;
    import lpbd_pkg::*;
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [PAGE_W-1:0] page_num;
    logic              mark_dirty;
    modport source (output valid, mode, page_num, mark_dirty, input ready);
    modport sink   (input valid, mode, page_num, mark_dirty, output ready);
endinterface

// result channel
interface lpbd_rsp_if;
    import lpbd_pkg::*;
    logic               valid;
    logic               ready;
    logic               found;
    logic [FRAME_W-1:0] frame;
    logic               writeback;
    logic [PAGE_W-1:0]  wb_page;
    logic               read_fill;
    logic               erase_block;
    logic               range_error;
    logic               last;
    modport source (output valid, found, frame, writeback, wb_page, read_fill,
                    erase_block, range_error, last, input ready);
    modport sink   (input valid, found, frame, writeback, wb_page, read_fill,
                    erase_block, range_error, last, output ready);
endinterface

// configuration write channel
interface lpbd_cfg_if;
    import lpbd_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ src/lpbd_ctrl.sv @@
`timescale 1ns / 1ps

module lpbd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lpbd_pkg::lpbd_sts_t sts,
    output lpbd_pkg::lpbd_cmd_t cmd
);
    import lpbd_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (sts.flush_all && sts.pend_any)
                begin
                    state_next = S_FLUSH;
                end
                else if (sts.out_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_FLUSH:
            begin
                if (sts.scan_hit)
                begin
                    if (sts.out_free)
                    begin
                        cmd.emit = 1'b1;
                        if (sts.scan_last)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            cmd.advance = 1'b1;
                        end
                    end
                end
                else
                begin
                    cmd.advance = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ src/lpbd_datapath.sv @@
`timescale 1ns / 1ps

module lpbd_datapath #(
    parameter int FRAME_SLOTS  = 16,
    parameter int PAGE_ID_BITS = 20
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lpbd_pkg::lpbd_cmd_t         cmd,
    output lpbd_pkg::lpbd_sts_t         sts,
    input  logic [lpbd_pkg::MODE_W-1:0] req_mode,
    input  logic [lpbd_pkg::PAGE_W-1:0] req_page_num,
    input  logic                        req_mark_dirty,
    lpbd_cfg_if.sink                    cfg,
    lpbd_rsp_if.source                  rsp
);
    import lpbd_pkg::*;

    localparam int IDX_W = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
    localparam int CNT_W = $clog2(FRAME_SLOTS + 1);
    localparam int CAP_W = (CNT_W > FIU_W) ? CNT_W : FIU_W;
    localparam int RNG_W = (PAGE_ID_BITS > TOTAL_W) ? PAGE_ID_BITS : TOTAL_W;
    localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'(FRAME_SLOTS);

    // width helpers
    function automatic logic [FRAME_W-1:0] to_frame(input logic [IDX_W-1:0] idx);
        logic [IDX_W+FRAME_W-1:0] ext;
        ext = {{FRAME_W{1'b0}}, idx};
        return ext[FRAME_W-1:0];
    endfunction

    function automatic logic [PAGE_W-1:0] to_wb(input logic [PAGE_ID_BITS-1:0] pg);
        logic [PAGE_ID_BITS+PAGE_W-1:0] ext;
        ext = {{PAGE_W{1'b0}}, pg};
        return ext[PAGE_W-1:0];
    endfunction

    function automatic logic [PAGE_ID_BITS-1:0] to_page(input logic [PAGE_W-1:0] pg);
        logic [PAGE_ID_BITS+PAGE_W-1:0] ext;
        ext = {{PAGE_ID_BITS{1'b0}}, pg};
        return ext[PAGE_ID_BITS-1:0];
    endfunction

    function automatic logic out_of_range(input logic [PAGE_ID_BITS-1:0] pg,
                                          input logic [TOTAL_W-1:0] total);
        logic [RNG_W-1:0] a;
        logic [RNG_W-1:0] b;
        a = RNG_W'(pg);
        b = RNG_W'(total);
        return (a >= b);
    endfunction

    // lowest set bit
    function automatic logic [IDX_W-1:0] lowest(input logic [FRAME_SLOTS-1:0] v);
        logic [IDX_W-1:0] r;
        r = '0;
        for (int i = FRAME_SLOTS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = IDX_W'(i);
            end
        end
        return r;
    endfunction

    // configuration registers
    logic [FIU_W-1:0]   fiu_reg;
    logic [TOTAL_W-1:0] total_reg;

    // captured request and lookup results
    logic [MODE_W-1:0]       req_mode_reg;
    logic [PAGE_ID_BITS-1:0] req_page_reg;
    logic                    req_dirty_reg;
    logic                    hit_reg;
    logic [IDX_W-1:0]        hit_idx_reg;
    logic [IDX_W-1:0]        hit_rank_reg;
    logic [IDX_W-1:0]        victim_reg;

    // directory state
    logic [FRAME_SLOTS-1:0]  valid_reg;
    logic [FRAME_SLOTS-1:0]  valid_next;
    logic [FRAME_SLOTS-1:0]  mod_reg;
    logic [FRAME_SLOTS-1:0]  mod_next;
    logic [IDX_W-1:0]        rank_reg  [FRAME_SLOTS];
    logic [IDX_W-1:0]        rank_next [FRAME_SLOTS];
    logic [PAGE_ID_BITS-1:0] slot_page_reg [FRAME_SLOTS];
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;

    // flush-all scan
    logic [FRAME_SLOTS-1:0] pend_reg;
    logic [FRAME_SLOTS-1:0] pend_next;
    logic [IDX_W-1:0]       scan_reg;
    logic [IDX_W-1:0]       scan_next;

    // result register
    lpbd_rsp_t rsp_reg;
    lpbd_rsp_t rsp_next;
    logic      rsp_valid_reg;
    logic      rsp_valid_next;

    logic [PAGE_ID_BITS-1:0] req_page_in;
    logic [FRAME_SLOTS-1:0]  hit_vec;
    logic [FRAME_SLOTS-1:0]  victim_vec;
    logic [IDX_W-1:0]        hit_idx_in;
    logic [CAP_W-1:0]        fiu_ext;
    logic [CAP_W-1:0]        cap;
    logic                    evict;
    logic [FRAME_SLOTS-1:0]  victim_oh;
    logic [FRAME_SLOTS-1:0]  valid_after;
    logic [IDX_W-1:0]        free_idx;
    logic [FRAME_SLOTS-1:0]  scan_oh;
    logic [FRAME_SLOTS-1:0]  pend_others;
    logic                    page_we;
    logic                    load;
    lpbd_rsp_t               item;

    // associative match against the incoming page, victim by rank
    always_comb
    begin
        req_page_in = to_page(req_page_num);
        for (int i = 0; i < FRAME_SLOTS; i++)
        begin
            hit_vec[i]    = valid_reg[i] && (slot_page_reg[i] == req_page_in);
            victim_vec[i] = valid_reg[i] &&
                            (CNT_W'(rank_reg[i]) == (count_reg - CNT_W'(1)));
        end
        hit_idx_in = lowest(hit_vec);
    end

    // capacity and free frame after eviction
    always_comb
    begin
        fiu_ext = CAP_W'(fiu_reg);
        if (fiu_reg == '0)
        begin
            cap = CAP_W'(1);
        end
        else if (fiu_ext > CAP_MAX)
        begin
            cap = CAP_MAX;
        end
        else
        begin
            cap = fiu_ext;
        end
        evict     = !hit_reg && (CAP_W'(count_reg) >= cap);
        victim_oh = '0;
        victim_oh[victim_reg] = evict;
        valid_after = valid_reg & ~victim_oh;
        free_idx    = lowest(~valid_after);
        scan_oh     = '0;
        scan_oh[scan_reg] = 1'b1;
        pend_others = pend_reg & ~scan_oh;
    end

    // directory update and result forming
    always_comb
    begin
        valid_next = valid_reg;
        mod_next   = mod_reg;
        rank_next  = rank_reg;
        count_next = count_reg;
        pend_next  = pend_reg;
        page_we    = 1'b0;
        load       = 1'b0;
        item       = '0;
        rsp_next   = rsp_reg;

        if (cmd.capture)
        begin
            pend_next = valid_reg & mod_reg;
        end

        if (cmd.exec)
        begin
            load      = 1'b1;
            item.last = 1'b1;
            case (req_mode_reg)
                MODE_FETCH:
                begin
                    if (hit_reg)
                    begin
                        for (int i = 0; i < FRAME_SLOTS; i++)
                        begin
                            if (valid_reg[i] && (rank_reg[i] < hit_rank_reg))
                            begin
                                rank_next[i] = rank_reg[i] + IDX_W'(1);
                            end
                        end
                        rank_next[hit_idx_reg] = '0;
                        item.found = 1'b1;
                        item.frame = to_frame(hit_idx_reg);
                    end
                    else
                    begin
                        if (evict)
                        begin
                            valid_next[victim_reg] = 1'b0;
                            mod_next[victim_reg]   = 1'b0;
                            if (mod_reg[victim_reg])
                            begin
                                item.writeback   = 1'b1;
                                item.wb_page     = to_wb(slot_page_reg[victim_reg]);
                                item.range_error = out_of_range(slot_page_reg[victim_reg],
                                                                total_reg);
                            end
                        end
                        for (int i = 0; i < FRAME_SLOTS; i++)
                        begin
                            if (valid_after[i])
                            begin
                                rank_next[i] = rank_reg[i] + IDX_W'(1);
                            end
                        end
                        valid_next[free_idx] = 1'b1;
                        mod_next[free_idx]   = 1'b0;
                        rank_next[free_idx]  = '0;
                        page_we              = 1'b1;
                        if (!evict)
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                        item.frame       = to_frame(free_idx);
                        item.read_fill   = 1'b1;
                        item.range_error = item.range_error |
                                           out_of_range(req_page_reg, total_reg);
                    end
                end
                MODE_UNPIN:
                begin
                    if (hit_reg)
                    begin
                        if (req_dirty_reg)
                        begin
                            mod_next[hit_idx_reg] = 1'b1;
                        end
                        item.found = 1'b1;
                        item.frame = to_frame(hit_idx_reg);
                    end
                end
                MODE_FLUSH:
                begin
                    if (hit_reg)
                    begin
                        item.found       = 1'b1;
                        item.frame       = to_frame(hit_idx_reg);
                        item.writeback   = 1'b1;
                        item.wb_page     = to_wb(req_page_reg);
                        item.range_error = out_of_range(req_page_reg, total_reg);
                    end
                end
                MODE_DELETE:
                begin
                    if (hit_reg)
                    begin
                        for (int i = 0; i < FRAME_SLOTS; i++)
                        begin
                            if (valid_reg[i] && (rank_reg[i] > hit_rank_reg))
                            begin
                                rank_next[i] = rank_reg[i] - IDX_W'(1);
                            end
                        end
                        valid_next[hit_idx_reg] = 1'b0;
                        mod_next[hit_idx_reg]   = 1'b0;
                        rank_next[hit_idx_reg]  = '0;
                        count_next       = count_reg - CNT_W'(1);
                        item.found       = 1'b1;
                        item.frame       = to_frame(hit_idx_reg);
                        item.erase_block = 1'b1;
                        item.range_error = out_of_range(req_page_reg, total_reg);
                    end
                end
                default:
                begin
                    // flush all with nothing dirty, or unknown mode: empty item
                    item.last = 1'b1;
                end
            endcase
        end

        // one dirty frame written back per step
        if (cmd.emit)
        begin
            load             = 1'b1;
            item.found       = 1'b1;
            item.frame       = to_frame(scan_reg);
            item.writeback   = 1'b1;
            item.wb_page     = to_wb(slot_page_reg[scan_reg]);
            item.range_error = out_of_range(slot_page_reg[scan_reg], total_reg);
            item.last        = (pend_others == '0);
            mod_next[scan_reg]  = 1'b0;
            pend_next[scan_reg] = 1'b0;
        end

        if (load)
        begin
            rsp_next = item;
        end
    end

    // scan index and result valid
    always_comb
    begin
        if (cmd.capture)
        begin
            scan_next = '0;
        end
        else if (cmd.advance)
        begin
            scan_next = scan_reg + IDX_W'(1);
        end
        else
        begin
            scan_next = scan_reg;
        end

        if (load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    // status to controller
    assign sts.out_free  = !rsp_valid_reg || rsp.ready;
    assign sts.flush_all = (req_mode_reg == MODE_FLUSH_ALL);
    assign sts.pend_any  = |pend_reg;
    assign sts.scan_hit  = pend_reg[scan_reg];
    assign sts.scan_last = (pend_others == '0);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fiu_reg       <= FIU_RESET;
            total_reg     <= TOTAL_RESET;
            valid_reg     <= '0;
            mod_reg       <= '0;
            count_reg     <= '0;
            pend_reg      <= '0;
            scan_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < FRAME_SLOTS; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_FRAMES_IN_USE: fiu_reg   <= cfg.data[FIU_W-1:0];
                    REG_TOTAL_PAGES:   total_reg <= cfg.data[TOTAL_W-1:0];
                    default:           ;
                endcase
            end
            valid_reg     <= valid_next;
            mod_reg       <= mod_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            scan_reg      <= scan_next;
            rsp_valid_reg <= rsp_valid_next;
            rank_reg      <= rank_next;
        end
    end

    // request capture and payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_mode_reg  <= req_mode;
            req_page_reg  <= req_page_in;
            req_dirty_reg <= req_mark_dirty;
            hit_reg       <= (|hit_vec) && (req_mode <= MODE_DELETE);
            hit_idx_reg   <= hit_idx_in;
            hit_rank_reg  <= rank_reg[hit_idx_in];
            victim_reg    <= lowest(victim_vec);
        end
        if (page_we)
        begin
            slot_page_reg[free_idx] <= req_page_reg;
        end
        rsp_reg <= rsp_next;
    end

    assign cfg.ready       = 1'b1;
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.found       = rsp_reg.found;
    assign rsp.frame       = rsp_reg.frame;
    assign rsp.writeback   = rsp_reg.writeback;
    assign rsp.wb_page     = rsp_reg.wb_page;
    assign rsp.read_fill   = rsp_reg.read_fill;
    assign rsp.erase_block = rsp_reg.erase_block;
    assign rsp.range_error = rsp_reg.range_error;
    assign rsp.last        = rsp_reg.last;

endmodule

@@ src/lru_page_buffer_directory_top.sv @@
`timescale 1ns / 1ps

// Fully associative directory of resident pages with LRU replacement and dirty
// bits. A request is taken on the req channel when req.ready is high, which is
// only while no other request is in progress. For every request but flush-all,
// the accept cycle matches the page against all frames in parallel and picks
// the eviction victim by rank, and the execute state then updates the directory
// and loads the single result register once that register is free. Flush-all
// scans the frames up to the highest dirty frame and gives one item per dirty
// frame, or a single empty item when none is dirty. An item that is ready to be
// loaded while the result register still holds an untaken item waits until
// that item is taken. Configuration writes are taken in every cycle and must
// only be made while the block is idle. No clearing pass follows reset.
module lru_page_buffer_directory_top #(
    parameter int FRAME_SLOTS  = 16,
    parameter int PAGE_ID_BITS = 20
) (
    input  logic       clk,
    input  logic       rst_n,
    lpbd_cfg_if.sink   cfg,
    lpbd_req_if.sink   req,
    lpbd_rsp_if.source rsp
);
    import lpbd_pkg::*;

    lpbd_cmd_t cmd;
    lpbd_sts_t sts;
    logic      in_ready;

    assign req.ready = in_ready;

    // sequencing
    lpbd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // directory, lookup and result register
    lpbd_datapath #(
        .FRAME_SLOTS  (FRAME_SLOTS),
        .PAGE_ID_BITS (PAGE_ID_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .req_mode       (req.mode),
        .req_page_num   (req.page_num),
        .req_mark_dirty (req.mark_dirty),
        .cfg            (cfg),
        .rsp            (rsp)
    );

endmodule

@@ src/lpbd_chk.sv @@
`timescale 1ns / 1ps

module lpbd_chk (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_ready,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic                        found,
    input logic                        writeback,
    input logic [lpbd_pkg::PAGE_W-1:0] wb_page,
    input logic                        read_fill,
    input logic                        erase_block,
    input logic                        last
);

    // a result waiting to be taken holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(wb_page) && $stable(found)
                                     && $stable(last))
        else $error("stalled result item changed");

    // one request at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another in progress");

    // no write-back, no page number
    a_wb_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !writeback |-> wb_page == '0)
        else $error("wb_page set without writeback");

    // a fill comes only from a fetch miss, which ends its request
    a_fill_miss: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && read_fill |-> !found && last && !erase_block)
        else $error("read_fill on a hit or non-final item");

    // an erase comes only from a resident delete
    a_erase_hit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && erase_block |-> found && !writeback && last)
        else $error("erase_block on a bad item");

endmodule

bind lru_page_buffer_directory_top lpbd_chk u_lpbd_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .found       (rsp.found),
    .writeback   (rsp.writeback),
    .wb_page     (rsp.wb_page),
    .read_fill   (rsp.read_fill),
    .erase_block (rsp.erase_block),
    .last        (rsp.last)
);

@@ verif/lru_page_buffer_directory_top_tb.sv @@
`timescale 1ns / 1ps

module lru_page_buffer_directory_top_tb;
    import lpbd_pkg::*;

    localparam int FRAME_SLOTS = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 8;
    localparam int POOL_SIZE   = 24;

    // modes the block does not define
    localparam logic [MODE_W-1:0] MODE_SPARE_LO  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_MID = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI  = 3'd7;

    localparam logic [PAGE_W-1:0]     PAGE_TOP    = '1;
    localparam logic [CFG_DATA_W-1:0] TOTAL_FULL  = 21'h100000;

    logic clk;
    logic rst_n;

    lpbd_cfg_if cfg_bus ();
    lpbd_req_if req_bus ();
    lpbd_rsp_if rsp_bus ();

    lru_page_buffer_directory_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_bus),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // mirror of the directory
    logic              frame_used  [FRAME_SLOTS];
    logic [PAGE_W-1:0] frame_page  [FRAME_SLOTS];
    logic              frame_dirty [FRAME_SLOTS];
    int                frame_age   [FRAME_SLOTS];
    logic [FIU_W-1:0]   capacity_reg;
    logic [TOTAL_W-1:0] total_pages_reg;

    lpbd_rsp_t         results_due [$];
    logic [PAGE_W-1:0] page_pool [POOL_SIZE];
    int                error_count = 0;
    int                cycle_count = 0;
    bit                back_to_back = 1'b0;

    // clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // work out the result items of one accepted request and update the mirror
    function automatic void predict_request(input logic [MODE_W-1:0] mode,
                                            input logic [PAGE_W-1:0] page,
                                            input logic mark);
        int i;
        int hit;
        int victim;
        int slot;
        int cap;
        int used;
        int top;
        int age;
        lpbd_rsp_t res;
        res      = '0;
        res.last = 1'b1;
        hit      = -1;
        if (mode <= MODE_DELETE)
        begin
            for (i = 0; i < FRAME_SLOTS; i++)
                if (hit < 0 && frame_used[i] && frame_page[i] == page)
                    hit = i;
        end
        case (mode)
            MODE_FETCH:
            begin
                if (hit >= 0)
                begin
                    // hit: younger pages age by one, this one becomes newest
                    age = frame_age[hit];
                    for (i = 0; i < FRAME_SLOTS; i++)
                        if (frame_used[i] && frame_age[i] < age)
                            frame_age[i]++;
                    frame_age[hit] = 0;
                    res.found      = 1'b1;
                    res.frame      = hit[FRAME_W-1:0];
                end
                else
                begin
                    // miss: clamp capacity, evict the oldest page if full
                    cap = capacity_reg;
                    if (cap < 1)
                        cap = 1;
                    if (cap > FRAME_SLOTS)
                        cap = FRAME_SLOTS;
                    used = 0;
                    for (i = 0; i < FRAME_SLOTS; i++)
                        if (frame_used[i])
                            used++;
                    if (used >= cap)
                    begin
                        victim = -1;
                        for (i = 0; i < FRAME_SLOTS; i++)
                            if (frame_used[i] && (victim < 0 || frame_age[i] > frame_age[victim]))
                                victim = i;
                        if (victim >= 0)
                        begin
                            if (frame_dirty[victim])
                            begin
                                res.writeback   = 1'b1;
                                res.wb_page     = frame_page[victim];
                                res.range_error = ({1'b0, frame_page[victim]} >= total_pages_reg);
                            end
                            frame_used[victim]  = 1'b0;
                            frame_dirty[victim] = 1'b0;
                        end
                    end
                    // install in the lowest free frame, everyone else ages
                    slot = -1;
                    for (i = 0; i < FRAME_SLOTS; i++)
                    begin
                        if (!frame_used[i])
                        begin
                            if (slot < 0)
                                slot = i;
                        end
                        else
                            frame_age[i]++;
                    end
                    if (slot < 0)
                        slot = 0;
                    frame_used[slot]  = 1'b1;
                    frame_page[slot]  = page;
                    frame_dirty[slot] = 1'b0;
                    frame_age[slot]   = 0;
                    res.range_error   = res.range_error | ({1'b0, page} >= total_pages_reg);
                    res.read_fill     = 1'b1;
                    res.frame         = slot[FRAME_W-1:0];
                end
                results_due = {results_due, res};
            end
            MODE_UNPIN:
            begin
                if (hit >= 0)
                begin
                    if (mark)
                        frame_dirty[hit] = 1'b1;
                    res.found = 1'b1;
                    res.frame = hit[FRAME_W-1:0];
                end
                results_due = {results_due, res};
            end
            MODE_FLUSH:
            begin
                if (hit >= 0)
                begin
                    res.found       = 1'b1;
                    res.frame       = hit[FRAME_W-1:0];
                    res.writeback   = 1'b1;
                    res.wb_page     = page;
                    res.range_error = ({1'b0, page} >= total_pages_reg);
                end
                results_due = {results_due, res};
            end
            MODE_DELETE:
            begin
                if (hit >= 0)
                begin
                    // free the entry, older pages close the gap
                    age              = frame_age[hit];
                    frame_used[hit]  = 1'b0;
                    frame_dirty[hit] = 1'b0;
                    frame_age[hit]   = 0;
                    for (i = 0; i < FRAME_SLOTS; i++)
                        if (frame_used[i] && frame_age[i] > age)
                            frame_age[i]--;
                    res.found       = 1'b1;
                    res.frame       = hit[FRAME_W-1:0];
                    res.erase_block = 1'b1;
                    res.range_error = ({1'b0, page} >= total_pages_reg);
                end
                results_due = {results_due, res};
            end
            MODE_FLUSH_ALL:
            begin
                top = -1;
                for (i = 0; i < FRAME_SLOTS; i++)
                    if (frame_used[i] && frame_dirty[i])
                        top = i;
                if (top < 0)
                    results_due = {results_due, res};
                else
                begin
                    // one item per dirty frame, ascending
                    for (i = 0; i < FRAME_SLOTS; i++)
                    begin
                        if (frame_used[i] && frame_dirty[i])
                        begin
                            res             = '0;
                            res.found       = 1'b1;
                            res.frame       = i[FRAME_W-1:0];
                            res.writeback   = 1'b1;
                            res.wb_page     = frame_page[i];
                            res.range_error = ({1'b0, frame_page[i]} >= total_pages_reg);
                            res.last        = (i == top);
                            frame_dirty[i]  = 1'b0;
                            results_due = {results_due, res};
                        end
                    end
                end
            end
            default:
            begin
                results_due = {results_due, res};
            end
        endcase
    endfunction

    // compare one result item with the oldest expectation
    task automatic check_result();
        lpbd_rsp_t want;
        if (results_due.size() == 0)
        begin
            $error("unexpected result item: frame %0d last %0d", rsp_bus.frame, rsp_bus.last);
            error_count++;
        end
        else
        begin
            want = results_due.pop_front();
            if (rsp_bus.found !== want.found)
            begin
                $error("found: expected %0d, got %0d", want.found, rsp_bus.found);
                error_count++;
            end
            if (rsp_bus.frame !== want.frame)
            begin
                $error("frame: expected %0d, got %0d", want.frame, rsp_bus.frame);
                error_count++;
            end
            if (rsp_bus.writeback !== want.writeback)
            begin
                $error("writeback: expected %0d, got %0d", want.writeback, rsp_bus.writeback);
                error_count++;
            end
            if (rsp_bus.wb_page !== want.wb_page)
            begin
                $error("wb_page: expected %h, got %h", want.wb_page, rsp_bus.wb_page);
                error_count++;
            end
            if (rsp_bus.read_fill !== want.read_fill)
            begin
                $error("read_fill: expected %0d, got %0d", want.read_fill, rsp_bus.read_fill);
                error_count++;
            end
            if (rsp_bus.erase_block !== want.erase_block)
            begin
                $error("erase_block: expected %0d, got %0d", want.erase_block,
                       rsp_bus.erase_block);
                error_count++;
            end
            if (rsp_bus.range_error !== want.range_error)
            begin
                $error("range_error: expected %0d, got %0d", want.range_error,
                       rsp_bus.range_error);
                error_count++;
            end
            if (rsp_bus.last !== want.last)
            begin
                $error("last: expected %0d, got %0d", want.last, rsp_bus.last);
                error_count++;
            end
        end
    endtask

    // result side: take items and stall at random
    initial
    begin : result_side
        int hold;
        hold = 0;
        rsp_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
            begin
                check_result();
                hold = back_to_back ? 0 : $urandom_range(0, 4);
            end
            if (hold > 0)
            begin
                rsp_bus.ready <= 1'b0;
                hold--;
            end
            else
                rsp_bus.ready <= 1'b1;
        end
    end

    // send one request item, valid stays high afterwards
    task automatic send_request(input logic [MODE_W-1:0] mode,
                                input logic [PAGE_W-1:0] page,
                                input logic mark);
        int gap;
        gap = back_to_back ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_bus.valid      <= 1'b1;
        req_bus.mode       <= mode;
        req_bus.page_num   <= page;
        req_bus.mark_dirty <= mark;
        do
            @(posedge clk);
        while (req_bus.ready !== 1'b1);
        predict_request(mode, page, mark);
    endtask

    // stop requests and wait until the block has gone quiet
    task automatic drain();
        req_bus.valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] reg_index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= reg_index;
        cfg_bus.data  <= value;
        do
            @(posedge clk);
        while (cfg_bus.ready !== 1'b1);
        cfg_bus.valid <= 1'b0;
        if (reg_index == REG_FRAMES_IN_USE)
            capacity_reg = value[FIU_W-1:0];
        else if (reg_index == REG_TOTAL_PAGES)
            total_pages_reg = value[TOTAL_W-1:0];
        @(posedge clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] frames,
                             input logic [CFG_DATA_W-1:0] total);
        write_reg(REG_FRAMES_IN_USE, frames);
        write_reg(REG_TOTAL_PAGES, total);
    endtask

    // random mix of requests over a small page pool so that hits are common
    task automatic run_traffic(input int items);
        int k;
        int pick;
        logic [MODE_W-1:0] mode;
        logic [PAGE_W-1:0] page;
        logic              mark;
        for (k = 0; k < POOL_SIZE; k++)
        begin
            case ($urandom_range(0, 3))
                0: page_pool[k] = PAGE_W'($urandom_range(0, 31));
                1: page_pool[k] = PAGE_TOP - PAGE_W'($urandom_range(0, 31));
                2: page_pool[k] = PAGE_W'(total_pages_reg - 3 + $urandom_range(0, 5));
                default: page_pool[k] = PAGE_W'($urandom);
            endcase
        end
        for (k = 0; k < items; k++)
        begin
            if (k % 16 == 0)
                back_to_back = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 42)
                mode = MODE_FETCH;
            else if (pick < 62)
                mode = MODE_UNPIN;
            else if (pick < 74)
                mode = MODE_FLUSH;
            else if (pick < 84)
                mode = MODE_DELETE;
            else if (pick < 92)
                mode = MODE_FLUSH_ALL;
            else
                mode = MODE_W'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO));
            if ($urandom_range(0, 9) == 0)
                page = PAGE_W'($urandom);
            else
                page = page_pool[$urandom_range(0, POOL_SIZE - 1)];
            mark = ($urandom_range(0, 9) < 7);
            send_request(mode, page, mark);
        end
        back_to_back = 1'b0;
        drain();
    endtask

    // each mode, hits and misses, flush-all with and without dirty pages
    task automatic test_directed();
        send_request(MODE_FLUSH_ALL, 20'h00000, 1'b0);
        send_request(MODE_FETCH, 20'h00000, 1'b1);
        send_request(MODE_FETCH, PAGE_TOP, 1'b0);
        send_request(MODE_FETCH, 20'h00000, 1'b0);
        send_request(MODE_UNPIN, 20'h00000, 1'b1);
        send_request(MODE_UNPIN, PAGE_TOP, 1'b0);
        send_request(MODE_UNPIN, 20'h12345, 1'b1);
        send_request(MODE_FLUSH, 20'h00000, 1'b0);
        send_request(MODE_FLUSH, 20'h00005, 1'b1);
        send_request(MODE_UNPIN, PAGE_TOP, 1'b1);
        send_request(MODE_FLUSH_ALL, PAGE_TOP, 1'b1);
        send_request(MODE_FLUSH_ALL, 20'h00000, 1'b0);
        send_request(MODE_DELETE, PAGE_TOP, 1'b0);
        send_request(MODE_DELETE, PAGE_TOP, 1'b1);
        send_request(MODE_SPARE_LO, 20'h00000, 1'b1);
        send_request(MODE_SPARE_MID, 20'h55555, 1'b0);
        send_request(MODE_SPARE_HI, PAGE_TOP, 1'b1);
        send_request(MODE_FETCH, 20'hAAAAA, 1'b0);
        send_request(MODE_FETCH, 20'h55555, 1'b1);
        send_request(MODE_FETCH, 20'h00000, 1'b0);
        send_request(MODE_DELETE, 20'h00000, 1'b0);
        send_request(MODE_FETCH, 20'h00000, 1'b0);
        drain();
    endtask

    // every block out of range, then a small backing store
    task automatic test_storage_bounds();
        configure(21'd1, 21'd0);
        run_traffic(35);
        configure(21'd5, 21'd10);
        run_traffic(60);
    endtask

    // capacity of zero acts as one, above the frame count acts as full
    task automatic test_capacity_clamp();
        configure(21'd0, TOTAL_FULL);
        run_traffic(35);
        configure(21'd31, TOTAL_FULL - 1);
        run_traffic(55);
    endtask

    // fill every frame, then lower the capacity below the count
    task automatic test_capacity_shrink();
        int k;
        configure(21'd16, TOTAL_FULL);
        for (k = 0; k < FRAME_SLOTS; k++)
            send_request(MODE_FETCH, PAGE_W'(20'h00400 + k), 1'b0);
        for (k = 0; k < 4; k++)
            send_request(MODE_UNPIN, PAGE_W'(20'h00400 + 3 * k), 1'b1);
        drain();
        configure(21'd3, 21'h000408);
        for (k = 0; k < 6; k++)
            send_request(MODE_FETCH, PAGE_W'(20'h00800 + k), 1'b0);
        run_traffic(30);
    endtask

    task automatic test_random_settings();
        int round;
        for (round = 0; round < 3; round++)
        begin
            configure(CFG_DATA_W'($urandom_range(1, FRAME_SLOTS)),
                      ($urandom_range(0, 1) == 0) ? TOTAL_FULL
                                                  : CFG_DATA_W'($urandom_range(1, TOTAL_FULL)));
            run_traffic(50);
        end
    endtask

    // stimulus
    initial
    begin : stimulus
        int i;
        rst_n              <= 1'b0;
        req_bus.valid      <= 1'b0;
        req_bus.mode       <= MODE_FETCH;
        req_bus.page_num   <= '0;
        req_bus.mark_dirty <= 1'b0;
        cfg_bus.valid      <= 1'b0;
        cfg_bus.index      <= REG_FRAMES_IN_USE;
        cfg_bus.data       <= '0;
        capacity_reg    = FIU_RESET;
        total_pages_reg = TOTAL_RESET;
        for (i = 0; i < FRAME_SLOTS; i++)
        begin
            frame_used[i]  = 1'b0;
            frame_dirty[i] = 1'b0;
            frame_age[i]   = 0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_storage_bounds();
        test_capacity_clamp();
        test_capacity_shrink();
        test_random_settings();

        if (error_count == 0 && results_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
